// ----- src/crcfc_pkg.sv -----
// Package for the CRC-16 frame checker: beat types, constants and the byte CRC update.
package crcfc_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned CrcW  = 16;

  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly = 16'hA001;

  // Bytes held back from the body CRC (the trailing CRC field)
  localparam logic [1:0] SeenFull = 2'd2;

  // One input beat
  typedef struct packed {
    logic             last_byte;
    logic [DataW-1:0] data_byte;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    logic            too_short;
    logic            crc_match;
    logic [CrcW-1:0] crc_trailer;
    logic [CrcW-1:0] crc_body;
    logic [CrcW-1:0] crc_all;
  } result_t;

  // Reflected CRC-16 update over one byte, LSB first
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [DataW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-DataW){1'b0}}, b};
    for (int k = 0; k < DataW; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- src/crcfc_in_stage.sv -----
// Input register: holds one accepted beat until the core takes it.
module crcfc_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  crcfc_pkg::in_beat_t beat_i,
  output logic                valid_o,
  output crcfc_pkg::in_beat_t beat_o,
  input  logic                take_i
);

  logic                valid_q;
  crcfc_pkg::in_beat_t beat_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign beat_o  = beat_q;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      beat_q <= beat_i;
    end
  end

endmodule

// ----- src/crcfc_core.sv -----
// Frame state and CRC update: two CRC registers, a two-byte delay line and a byte count.
module crcfc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  crcfc_pkg::in_beat_t  beat_i,
  output crcfc_pkg::result_t   result_o
);

  logic [crcfc_pkg::CrcW-1:0]  crc_full_q, crc_full_d;
  logic [crcfc_pkg::CrcW-1:0]  crc_lag_q, crc_lag_d;
  logic [crcfc_pkg::DataW-1:0] older_q, older_d;
  logic [crcfc_pkg::DataW-1:0] newer_q, newer_d;
  logic [1:0]                  seen_q, seen_d;

  logic                        full;
  logic                        short_frame;
  logic [crcfc_pkg::CrcW-1:0]  all_next;
  logic [crcfc_pkg::CrcW-1:0]  lag_next;
  logic [crcfc_pkg::CrcW-1:0]  rx;

  // Both CRC updates run side by side
  always_comb begin
    full        = (seen_q == crcfc_pkg::SeenFull);
    short_frame = (seen_q == 2'd0);
    all_next    = crcfc_pkg::crc_byte(crc_full_q, beat_i.data_byte);
    lag_next    = full ? crcfc_pkg::crc_byte(crc_lag_q, older_q) : crc_lag_q;
    rx          = short_frame ? '0 : {newer_q, beat_i.data_byte};

    result_o.crc_all     = all_next;
    result_o.crc_body    = lag_next;
    result_o.crc_trailer = rx;
    result_o.crc_match   = !short_frame && (lag_next == rx);
    result_o.too_short   = short_frame;
  end

  // Next state: advance within a frame, back to the initial values after its last byte
  always_comb begin
    crc_full_d = crc_full_q;
    crc_lag_d  = crc_lag_q;
    older_d    = older_q;
    newer_d    = newer_q;
    seen_d     = seen_q;
    if (step_i) begin
      if (beat_i.last_byte) begin
        crc_full_d = crcfc_pkg::CrcInit;
        crc_lag_d  = crcfc_pkg::CrcInit;
        older_d    = '0;
        newer_d    = '0;
        seen_d     = '0;
      end else begin
        crc_full_d = all_next;
        crc_lag_d  = lag_next;
        older_d    = newer_q;
        newer_d    = beat_i.data_byte;
        seen_d     = full ? crcfc_pkg::SeenFull : seen_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_full_q <= crcfc_pkg::CrcInit;
      crc_lag_q  <= crcfc_pkg::CrcInit;
      older_q    <= '0;
      newer_q    <= '0;
      seen_q     <= '0;
    end else begin
      crc_full_q <= crc_full_d;
      crc_lag_q  <= crc_lag_d;
      older_q    <= older_d;
      newer_q    <= newer_d;
      seen_q     <= seen_d;
    end
  end

endmodule

// ----- src/crcfc_out_stage.sv -----
// Result register: holds one result beat until the downstream side takes it.
module crcfc_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  crcfc_pkg::result_t result_i,
  output logic               ready_o,
  output logic               valid_o,
  output crcfc_pkg::result_t result_o,
  input  logic               ready_i
);

  logic               valid_q;
  crcfc_pkg::result_t result_q;

  // Free when empty or being drained this cycle
  assign ready_o  = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

// ----- src/crc16_frame_checker.sv -----
// Top level of the CRC-16 frame checker: input register, CRC core and result register.
//
//   Channel  Dir  Beat contents
//   s_axis   in   tdata[7:0] data_byte, tlast last_byte
//   m_axis   out  tdata crc_all/crc_body/crc_trailer, tuser crc_match/too_short
//
// One byte per cycle while the result register can take each result; a result is valid
// once its last byte has passed the input register, both CRC updates and the result register.
// Reset is asynchronous, active low, and returns the frame state to CRC 0xFFFF.
// A stalled result holds only beats that end a frame; other bytes keep flowing.
module crc16_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [15:0] crc_all, [31:16] crc_body, [47:32] crc_trailer
  output logic [1:0]  m_axis_tuser_o    // [0] crc_match, [1] too_short
);

  crcfc_pkg::in_beat_t in_beat;
  crcfc_pkg::in_beat_t core_beat;
  crcfc_pkg::result_t  core_result;
  crcfc_pkg::result_t  out_result;
  logic                core_valid;
  logic                out_ready;
  logic                step;

  assign in_beat.data_byte = s_axis_tdata_i;
  assign in_beat.last_byte = s_axis_tlast_i;

  // A last byte waits only when the result register cannot take its result
  assign step = core_valid && (!core_beat.last_byte || out_ready);

  crcfc_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .beat_i  (in_beat),
    .valid_o (core_valid),
    .beat_o  (core_beat),
    .take_i  (step)
  );

  crcfc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .beat_i   (core_beat),
    .result_o (core_result)
  );

  crcfc_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step && core_beat.last_byte),
    .result_i (core_result),
    .ready_o  (out_ready),
    .valid_o  (m_axis_tvalid_o),
    .result_o (out_result),
    .ready_i  (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {out_result.crc_trailer, out_result.crc_body, out_result.crc_all};
  assign m_axis_tuser_o = {out_result.too_short, out_result.crc_match};

endmodule
